>>> hdl/mia_pkg.sv
// Package of the motion intensity accumulator: store geometry, register indexes,
// configuration and pipeline item types, and the square-root step used by the root pipeline.
// Depends on nothing; every other file of the block imports it.
package mia_pkg;

   localparam int unsigned MAX_PIXELS  = 524288;
   localparam int unsigned ADDR_W      = $clog2(MAX_PIXELS);
   localparam int unsigned STORE_W     = 9;

   localparam logic [15:0] DEPTH_NONE  = 16'd0;
   localparam logic [15:0] DEPTH_SAT   = 16'd255;

   localparam int unsigned ROOT_STEPS  = 16;
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned ROOT_STAGES = ROOT_STEPS / STEPS_PER_STAGE;

   localparam int unsigned DIV_PCT     = 100;
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned RECIP_MUL   = (2 ** RECIP_SHIFT + DIV_PCT - 1) / DIV_PCT;
   localparam int unsigned X_LIMIT     = 256 * DIV_PCT;
   localparam int unsigned XC_W        = $clog2(X_LIMIT);

   typedef enum logic [2:0] {
      CSR_FORWARD_ONLY     = 3'd0,
      CSR_DECAY_STEP       = 3'd1,
      CSR_GATE_MIN         = 3'd2,
      CSR_GATE_MAX         = 3'd3,
      CSR_GAIN_PERCENT     = 3'd4,
      CSR_MOTION_THRESHOLD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic        forward_only;
      logic [7:0]  decay_step;
      logic [7:0]  gate_min;
      logic [7:0]  gate_max;
      logic [13:0] gain_percent;
      logic [7:0]  motion_threshold;
   } cfg_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] res;
   } sq_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              invalid;
      sq_type            sq;
   } root_stage_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              invalid;
      logic [15:0]       root;
   } root_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              invalid;
      logic              pass;
      logic [29:0]       prod;
   } gain1_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              invalid;
      logic              pass;
      logic              over;
      logic [30:0]       scaled;
   } gain2_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              invalid;
      logic              pass;
      logic [7:0]        rise;
   } gain_item_type;

   function automatic sq_type sqrt_step(sq_type s, int unsigned k);
      logic [31:0] bitv;
      logic [31:0] trial;
      sq_type      r;
      bitv  = 32'(1) << (30 - 2 * k);
      trial = s.res + bitv;
      r     = s;
      if (s.rem >= trial) begin
         r.rem = s.rem - trial;
         r.res = (s.res >> 1) + bitv;
      end else begin
         r.res = s.res >> 1;
      end
      return r;
   endfunction

endpackage

>>> hdl/mia_root_pipe.sv
// Root pipeline: input register that forms the velocity magnitude, then the
// square-root stages, two result bits per stage. Depends on mia_pkg.
module mia_root_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  mia_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [mia_pkg::ADDR_W-1:0] in_addr,
   input  logic [15:0]                in_depth,
   input  logic signed [15:0]         in_velocity,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mia_pkg::root_item_type     out_item
);
   import mia_pkg::*;

   root_stage_type             stage_ff [ROOT_STAGES+1];
   root_stage_type             stage_in [ROOT_STAGES+1];
   logic [ROOT_STAGES:0]       valid_ff;
   logic [ROOT_STAGES:0]       valid_in;
   logic [ROOT_STAGES:0]       ready;
   logic [ROOT_STAGES:0]       src_valid;
   logic [15:0]                mag;

   always_comb begin
      if (in_velocity[15]) begin
         mag = 16'(-in_velocity);
      end else if (cfg.forward_only) begin
         mag = '0;
      end else begin
         mag = in_velocity;
      end
      stage_in[0].addr    = in_addr;
      stage_in[0].invalid = (in_depth == DEPTH_NONE) || (in_depth == DEPTH_SAT);
      stage_in[0].sq.rem  = {mag, 16'h0000};
      stage_in[0].sq.res  = '0;
   end

   assign src_valid[0]        = in_valid;
   assign ready[ROOT_STAGES]  = !valid_ff[ROOT_STAGES] || out_ready;
   assign in_ready            = ready[0];

   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_ready
      assign ready[g]       = !valid_ff[g] || ready[g+1];
      assign src_valid[g+1] = valid_ff[g];
   end

   for (genvar g = 1; g <= ROOT_STAGES; g++) begin : g_step
      always_comb begin
         stage_in[g]    = stage_ff[g-1];
         stage_in[g].sq = sqrt_step(sqrt_step(stage_ff[g-1].sq, STEPS_PER_STAGE * (g - 1)),
                                    STEPS_PER_STAGE * (g - 1) + 1);
      end
   end

   for (genvar g = 0; g <= ROOT_STAGES; g++) begin : g_stage
      assign valid_in[g] = ready[g] ? src_valid[g] : valid_ff[g];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[g] && src_valid[g]) begin
            stage_ff[g] <= stage_in[g];
         end
      end
   end

   assign out_valid        = valid_ff[ROOT_STAGES];
   assign out_item.addr    = stage_ff[ROOT_STAGES].addr;
   assign out_item.invalid = stage_ff[ROOT_STAGES].invalid;
   assign out_item.root    = stage_ff[ROOT_STAGES].sq.res[15:0];

endmodule

>>> hdl/mia_gain_pipe.sv
// Gain pipeline: gate check and root-by-gain product, scaling by one over
// 25600 through a reciprocal product, then the clamped rise. Depends on mia_pkg.
module mia_gain_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  mia_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mia_pkg::root_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mia_pkg::gain_item_type out_item
);
   import mia_pkg::*;

   gain1_type     s1_ff, s1_in;
   gain2_type     s2_ff, s2_in;
   gain_item_type s3_ff, s3_in;
   logic          v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic          ready1, ready2, ready3;
   logic [15:0]   gmin, gmax;
   logic [21:0]   x;
   logic [XC_W-1:0] xc;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign v1_in = ready1 ? in_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   always_comb begin
      gmin          = {cfg.gate_min, 8'h00};
      gmax          = {cfg.gate_max, 8'h00};
      s1_in.addr    = in_item.addr;
      s1_in.invalid = in_item.invalid;
      s1_in.pass    = (in_item.root != 16'd0) && !(in_item.root > gmax)
                      && !(in_item.root < gmin);
      s1_in.prod    = 30'(in_item.root) * 30'(cfg.gain_percent);

      x             = s1_ff.prod[29:8];
      s2_in.addr    = s1_ff.addr;
      s2_in.invalid = s1_ff.invalid;
      s2_in.pass    = s1_ff.pass;
      s2_in.over    = x >= 22'(X_LIMIT);
      xc            = s2_in.over ? XC_W'(X_LIMIT - 1) : x[XC_W-1:0];
      s2_in.scaled  = 31'(xc) * 31'(RECIP_MUL);

      s3_in.addr    = s2_ff.addr;
      s3_in.invalid = s2_ff.invalid;
      s3_in.pass    = s2_ff.pass;
      s3_in.rise    = s2_ff.over ? 8'hFF : s2_ff.scaled[RECIP_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         s1_ff <= s1_in;
      end
      if (ready2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (ready3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = s3_ff;

endmodule

>>> hdl/mia_store.sv
// Pixel store: intensity and motion memory with clearing sweep after reset,
// read-modify-write stage with same-address forwarding, result register. Depends on mia_pkg.
module mia_store (
   input  logic                   clock,
   input  logic                   reset,
   input  mia_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mia_pkg::gain_item_type in_item,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_intensity,
   output logic                   rsp_motion_bit
);
   import mia_pkg::*;

   logic [STORE_W-1:0] mem [MAX_PIXELS];

   logic               r_valid_ff, r_valid_in;
   gain_item_type      r_item_ff;
   logic [STORE_W-1:0] rd_ff;
   logic [STORE_W-1:0] fwd_data_ff;
   logic               fwd_hit_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_int_ff;
   logic               out_mot_ff;
   logic               clear_ff, clear_in;
   logic [ADDR_W-1:0]  clear_cnt_ff, clear_cnt_in;

   logic               out_ready, r_ready, r_move, load;
   logic [7:0]         cur_int, decay_val, next_int;
   logic               cur_mot, next_mot;
   logic [8:0]         sum;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [STORE_W-1:0] wr_data;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign r_move     = r_valid_ff && out_ready;
   assign r_ready    = !r_valid_ff || out_ready;
   assign load       = in_valid && r_ready;
   assign in_ready   = r_ready;
   assign r_valid_in = r_ready ? in_valid : r_valid_ff;
   assign out_valid_in = out_ready ? r_valid_ff : out_valid_ff;

   always_comb begin
      {cur_mot, cur_int} = fwd_hit_ff ? fwd_data_ff : rd_ff;
      decay_val = (cur_int > cfg.decay_step) ? cur_int - cfg.decay_step : 8'd0;
      sum       = {1'b0, cur_int} + {1'b0, r_item_ff.rise};
      if (r_item_ff.invalid || !r_item_ff.pass) begin
         next_int = decay_val;
      end else begin
         next_int = sum[8] ? 8'hFF : sum[7:0];
      end
      next_mot = r_item_ff.invalid ? cur_mot : (next_int > cfg.motion_threshold);
   end

   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = r_move;
         wr_addr = r_item_ff.addr;
         wr_data = {next_mot, next_int};
      end
      clear_cnt_in = clear_cnt_ff + 1'b1;
      clear_in     = clear_ff && (clear_cnt_ff != ADDR_W'(MAX_PIXELS - 1));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (load) begin
         rd_ff <= mem[in_item.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         if (clear_ff) begin
            clear_cnt_ff <= clear_cnt_in;
         end
         r_valid_ff   <= r_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r_item_ff   <= in_item;
         fwd_hit_ff  <= r_move && (r_item_ff.addr == in_item.addr);
         fwd_data_ff <= {next_mot, next_int};
      end
      if (r_move) begin
         out_int_ff <= next_int;
         out_mot_ff <= next_mot;
      end
   end

   assign busy           = clear_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_intensity  = out_int_ff;
   assign rsp_motion_bit = out_mot_ff;

endmodule

>>> hdl/motion_intensity_accumulator.sv
// Motion intensity accumulator top level: configuration registers and the
// root, gain and store pipelines. Depends on mia_pkg and the mia_* modules.
//
// One pixel transaction per clock while rsp_ready holds high and the store is
// not sweeping; each result passes 9 root stages, 3 gain stages, the store
// update stage and the result register. The rate is set by the pixel store,
// which reads and writes one entry per cycle; a pixel that hits an address
// still in flight sees the updated value through forwarding. After reset all
// 524288 store entries are swept to zero, one entry per cycle, and req_ready
// stays low until the sweep ends; configuration writes are taken meanwhile.
// Write configuration only while no pixel is in flight.
module motion_intensity_accumulator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mia_pkg::ADDR_W-1:0] req_pixel_addr,
   input  logic [15:0]                req_depth,
   input  logic signed [15:0]         req_velocity,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_intensity,
   output logic                       rsp_motion_bit,
   input  logic                       csr_write_en,
   input  logic [2:0]                 csr_index,
   input  logic [13:0]                csr_write_data
);
   import mia_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          busy;
   logic          root_in_ready, root_valid, root_ready;
   root_item_type root_item;
   logic          gain_valid, gain_ready;
   gain_item_type gain_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORWARD_ONLY:     cfg_in.forward_only     = csr_write_data[0];
            CSR_DECAY_STEP:       cfg_in.decay_step       = csr_write_data[7:0];
            CSR_GATE_MIN:         cfg_in.gate_min         = csr_write_data[7:0];
            CSR_GATE_MAX:         cfg_in.gate_max         = csr_write_data[7:0];
            CSR_GAIN_PERCENT:     cfg_in.gain_percent     = csr_write_data;
            CSR_MOTION_THRESHOLD: cfg_in.motion_threshold = csr_write_data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = root_in_ready && !busy;

   mia_root_pipe u_root (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid && !busy),
      .in_ready    (root_in_ready),
      .in_addr     (req_pixel_addr),
      .in_depth    (req_depth),
      .in_velocity (req_velocity),
      .out_valid   (root_valid),
      .out_ready   (root_ready),
      .out_item    (root_item)
   );

   mia_gain_pipe u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_item   (root_item),
      .out_valid (gain_valid),
      .out_ready (gain_ready),
      .out_item  (gain_item)
   );

   mia_store u_store (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (gain_valid),
      .in_ready       (gain_ready),
      .in_item        (gain_item),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_intensity  (rsp_intensity),
      .rsp_motion_bit (rsp_motion_bit)
   );

endmodule

>>> tb/tb.sv
// Self-checking testbench for motion_intensity_accumulator: directed and random pixel
// transactions against a per-pixel intensity tracker, with random request gaps and
// random response backpressure. Depends on mia_pkg and the motion_intensity_accumulator RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mia_pkg::*;

   localparam int unsigned STALL_LIMIT = 1_600_000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned PHASE_ITEMS = 190;

   typedef struct {
      bit [7:0] intensity;
      bit       motion;
   } pixel_outcome_type;

   class motion_tracker;
      bit [7:0]          level_mem [MAX_PIXELS];
      bit                motion_mem [MAX_PIXELS];
      cfg_type           cfg;
      pixel_outcome_type pending_outcomes [$];
      int unsigned       mismatches;

      function new();
         cfg = '0;
         mismatches = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [13:0] value);
         case (idx)
            CSR_FORWARD_ONLY:     cfg.forward_only     = value[0];
            CSR_DECAY_STEP:       cfg.decay_step       = value[7:0];
            CSR_GATE_MIN:         cfg.gate_min         = value[7:0];
            CSR_GATE_MAX:         cfg.gate_max         = value[7:0];
            CSR_GAIN_PERCENT:     cfg.gain_percent     = value;
            CSR_MOTION_THRESHOLD: cfg.motion_threshold = value[7:0];
            default: ;
         endcase
      endfunction

      function bit [15:0] root_q8_8(bit [15:0] mag);
         longint unsigned radicand;
         longint unsigned trial;
         bit [15:0]       root;
         radicand = longint'(mag) << 16;
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if (trial * trial <= radicand) root = trial[15:0];
         end
         return root;
      endfunction

      function bit [7:0] decayed(bit [7:0] cur);
         return (cur > cfg.decay_step) ? cur - cfg.decay_step : 8'd0;
      endfunction

      function void take_pixel(logic [ADDR_W-1:0] addr, logic [15:0] depth, logic [15:0] vel);
         pixel_outcome_type o;
         bit [7:0]          cur;
         bit [7:0]          next;
         int                v;
         bit [15:0]         mag;
         bit [15:0]         root;
         longint unsigned   sum;
         cur = level_mem[addr];
         if (depth == DEPTH_NONE || depth == DEPTH_SAT) begin
            next = decayed(cur);
            level_mem[addr] = next;
            o.intensity = next;
            o.motion = motion_mem[addr];
         end else begin
            v = $signed(vel);
            if (v < 0) mag = 16'(-v);
            else if (cfg.forward_only) mag = '0;
            else mag = 16'(v);
            root = root_q8_8(mag);
            if (root == 0 || root > {cfg.gate_max, 8'h00} || root < {cfg.gate_min, 8'h00}) begin
               next = decayed(cur);
            end else begin
               sum = 64'(cur) + (64'(root) * 64'(cfg.gain_percent)) / 64'd25600;
               next = (sum > 255) ? 8'd255 : sum[7:0];
            end
            level_mem[addr] = next;
            motion_mem[addr] = (next > cfg.motion_threshold);
            o.intensity = next;
            o.motion = motion_mem[addr];
         end
         pending_outcomes.push_back(o);
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(bit [7:0] intensity, bit motion);
         pixel_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("unexpected result intensity=%0d motion=%0d", intensity, motion));
            return;
         end
         o = pending_outcomes.pop_front();
         if (intensity != o.intensity)
            report($sformatf("intensity %0d, want %0d", intensity, o.intensity));
         if (motion != o.motion)
            report($sformatf("motion_bit %0d, want %0d", motion, o.motion));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ADDR_W-1:0]   req_pixel_addr;
   logic [15:0]         req_depth;
   logic signed [15:0]  req_velocity;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_intensity;
   logic                rsp_motion_bit;
   logic                csr_write_en;
   logic [2:0]          csr_index;
   logic [13:0]         csr_write_data;

   motion_tracker tracker = new();
   int unsigned   tx_mode = 1;
   int unsigned   rx_mode = 1;
   bit            hold_request = 0;
   int unsigned   stuck_cycles = 0;
   logic [ADDR_W-1:0] hot_addr [24];

   motion_intensity_accumulator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_addr (req_pixel_addr),
      .req_depth      (req_depth),
      .req_velocity   (req_velocity),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_intensity  (rsp_intensity),
      .rsp_motion_bit (rsp_motion_bit),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned gap_len(int unsigned mode);
      int unsigned r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_pixel(logic [ADDR_W-1:0] addr, logic [15:0] depth, logic [15:0] vel,
                             int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_pixel_addr <= addr;
      req_depth      <= depth;
      req_velocity   <= vel;
      do @(posedge clock); while (!req_ready);
      tracker.take_pixel(addr, depth, vel);
   endtask

   task automatic random_pixel();
      logic [ADDR_W-1:0] addr;
      logic [15:0]       depth;
      logic [15:0]       vel;
      logic [15:0]       mag;
      int unsigned       r;
      r = $urandom_range(0, 99);
      if (r < 15) addr = ADDR_W'($urandom);
      else addr = hot_addr[$urandom_range(0, 23)];
      r = $urandom_range(0, 99);
      if (r < 8) depth = DEPTH_NONE;
      else if (r < 16) depth = DEPTH_SAT;
      else if (r < 20) begin
         case ($urandom_range(0, 3))
            0: depth = 16'd1;
            1: depth = 16'd254;
            2: depth = 16'd256;
            default: depth = 16'hFFFF;
         endcase
      end else depth = 16'($urandom_range(1, 65535));
      r = $urandom_range(0, 99);
      if (r < 30) vel = 16'($urandom);
      else if (r < 60) vel = 16'($urandom_range(0, 800)) - 16'd400;
      else if (r < 70) begin
         case ($urandom_range(0, 4))
            0: vel = 16'h8000;
            1: vel = 16'h7FFF;
            2: vel = 16'h0000;
            3: vel = 16'hFFFF;
            default: vel = 16'h0001;
         endcase
      end else begin
         mag = 16'($urandom_range(0, 32767));
         vel = $urandom_range(0, 1) ? -mag : mag;
      end
      send_pixel(addr, depth, vel, gap_len(tx_mode));
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [13:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic write_config(logic fwd, logic [7:0] decay, logic [7:0] gmin,
                               logic [7:0] gmax, logic [13:0] gain, logic [7:0] thr);
      write_reg(CSR_FORWARD_ONLY, 14'(fwd));
      write_reg(CSR_DECAY_STEP, 14'(decay));
      write_reg(CSR_GATE_MIN, 14'(gmin));
      write_reg(CSR_GATE_MAX, 14'(gmax));
      write_reg(CSR_GAIN_PERCENT, gain);
      write_reg(CSR_MOTION_THRESHOLD, 14'(thr));
   endtask

   task automatic run_phase(logic fwd, logic [7:0] decay, logic [7:0] gmin, logic [7:0] gmax,
                            logic [13:0] gain, logic [7:0] thr, int unsigned tx,
                            int unsigned rx, bit hold);
      settle();
      write_config(fwd, decay, gmin, gmax, gain, thr);
      tx_mode = tx;
      rx_mode = rx;
      hold_request = hold;
      repeat (PHASE_ITEMS) random_pixel();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_intensity, rsp_motion_bit);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : receiver
      int unsigned hold_cnt;
      int unsigned g;
      hold_cnt = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            g = gap_len(rx_mode);
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold_cnt = g - 1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [7:0] gmin;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_addr = '0;
      req_depth      = '0;
      req_velocity   = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_FORWARD_ONLY;
      csr_write_data = '0;
      hot_addr[0] = '0;
      hot_addr[1] = '1;
      for (int i = 2; i < 24; i++) hot_addr[i] = ADDR_W'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_config(1'b0, 8'd5, 8'd0, 8'd182, 14'd100, 8'd20);
      send_pixel(19'd0, 16'd1000, 16'h8000, 0);
      send_pixel(19'd0, 16'd1000, 16'h7FFF, 0);
      send_pixel(19'd0, DEPTH_NONE, 16'd100, 0);
      send_pixel(19'd0, DEPTH_SAT, 16'(-5), 0);
      send_pixel(19'h7FFFF, 16'hFFFF, 16'h0000, 0);
      send_pixel(19'h7FFFF, 16'd254, 16'hFFFF, 0);
      send_pixel(19'h7FFFF, 16'd256, 16'h0001, 0);
      send_pixel(19'd1, 16'd1, 16'h7FFF, 0);
      send_pixel(19'd1, 16'hFFFF, 16'(-100), 0);
      send_pixel(19'h2AAAA, 16'h5555, 16'h5555, 0);
      send_pixel(19'h55555, 16'hAAAA, 16'hAAAA, 0);
      settle();
      write_config(1'b1, 8'd255, 8'd10, 8'd20, 14'h3FFF, 8'd0);
      send_pixel(19'd3, 16'd500, 16'd50, 0);
      send_pixel(19'd3, 16'd500, 16'(-50), 0);
      send_pixel(19'd3, 16'd500, 16'(-200), 0);
      send_pixel(19'd3, 16'd500, 16'(-1000), 0);
      send_pixel(19'd3, 16'd500, 16'(-100), 0);
      send_pixel(19'd3, 16'd500, 16'(-400), 0);
      send_pixel(19'd3, DEPTH_NONE, 16'(-400), 0);

      run_phase(1'b1, 8'd0, 8'd0, 8'd255, 14'd10000, 8'd0, 1, 1, 0);
      run_phase(1'b0, 8'd255, 8'd182, 8'd182, 14'h3FFF, 8'd255, 0, 1, 1);
      run_phase(1'b0, 8'd1, 8'd0, 8'd60, 14'd0, 8'd100, 0, 0, 0);
      repeat (3) begin
         gmin = 8'($urandom_range(0, 40));
         run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(0, 12)), gmin,
                   8'($urandom_range(gmin, 255)), 14'($urandom_range(0, 16383)),
                   8'($urandom_range(0, 255)), 1, 1, 0);
      end

      settle();
      if (tracker.pending_outcomes.size() != 0) tracker.report("results missing at end");
      if (tracker.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
